>>> hw/rtl/mi3_pkg.sv
// Shared constants and types for the 3x3 matrix inverse pipeline.
// Used by every module under hw/rtl but mi3_checker; depends on nothing.
package mi3_pkg;
  localparam int N_ENT = 9;
  localparam int ROW_N = 3;
  localparam int THR_W = 31;

  typedef logic [THR_W-1:0] thr_t;

  typedef struct packed {
    logic sing;
    logic neg;
  } tag_t;

  localparam int unsigned COF_IDX [N_ENT][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  localparam int unsigned DET_ADJ [ROW_N] = '{0, 3, 6};
endpackage

>>> hw/rtl/matrix_inverse_3x3.sv
// Inverse of a signed fixed-point 3x3 matrix by the adjugate method.
// Depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_divider.
//
// Input: drive the nine entries on in_m00..in_m22 and pulse start; a word is
// taken at each clock edge with start high and busy low. busy is low except
// while rst_n is low, so a new matrix can enter every cycle.
// Output: each result word appears on out_r00..out_r22, out_singular and
// out_saturated for one cycle, marked by out_valid. There is one result per
// input, in input order, one per cycle at most.
// The restoring dividers form nine lanes, one quotient bit per stage over
// ENTRY_WIDTH + 1 stages, behind eight stages of multiply, cofactor,
// determinant and threshold compare.
// Configuration: cfg_data carries singular_threshold; it is written when
// cfg_valid and cfg_ready are high. Write it only with the pipeline empty.
// Reset: synchronous, clears all valid bits and the threshold to zero.
// The receiver cannot stall, so out_valid is never held back.
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ENTRY_WIDTH-1:0] in_m00,
  input  logic signed [ENTRY_WIDTH-1:0] in_m01,
  input  logic signed [ENTRY_WIDTH-1:0] in_m02,
  input  logic signed [ENTRY_WIDTH-1:0] in_m10,
  input  logic signed [ENTRY_WIDTH-1:0] in_m11,
  input  logic signed [ENTRY_WIDTH-1:0] in_m12,
  input  logic signed [ENTRY_WIDTH-1:0] in_m20,
  input  logic signed [ENTRY_WIDTH-1:0] in_m21,
  input  logic signed [ENTRY_WIDTH-1:0] in_m22,
  output logic                          out_valid,
  output logic signed [ENTRY_WIDTH-1:0] out_r00,
  output logic signed [ENTRY_WIDTH-1:0] out_r01,
  output logic signed [ENTRY_WIDTH-1:0] out_r02,
  output logic signed [ENTRY_WIDTH-1:0] out_r10,
  output logic signed [ENTRY_WIDTH-1:0] out_r11,
  output logic signed [ENTRY_WIDTH-1:0] out_r12,
  output logic signed [ENTRY_WIDTH-1:0] out_r20,
  output logic signed [ENTRY_WIDTH-1:0] out_r21,
  output logic signed [ENTRY_WIDTH-1:0] out_r22,
  output logic                          out_singular,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  thr_t                          cfg_data
);
  localparam int E = ENTRY_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int C = 2 * E + 1;
  localparam int D = 3 * E + 3;
  localparam logic [E-1:0] MAX_VAL = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MIN_VAL = {1'b1, {(E-1){1'b0}}};
  localparam logic         ONE_SAT = (F >= E - 1);
  localparam logic [E-1:0] ONE_VAL = ONE_SAT ? MAX_VAL : (E'(1) << F);

  thr_t                thr_r;
  logic                acc;
  logic signed [E-1:0] m_in [N_ENT];
  logic                cf_valid;
  logic signed [C-1:0] adj [N_ENT];
  logic signed [E-1:0] row0 [ROW_N];
  logic                dt_valid;
  logic [D-1:0]        mag;
  logic [C-1:0]        amag [N_ENT];
  tag_t                tag [N_ENT];
  logic                dv_valid [N_ENT];
  logic [E:0]          quo [N_ENT];
  logic                ovf [N_ENT];
  tag_t                dtag [N_ENT];

  logic [E-1:0]        res_nxt [N_ENT];
  logic                lsat_nxt [N_ENT];
  logic                sat_nxt;
  logic                ov_r;
  logic [E-1:0]        res_r [N_ENT];
  logic                sing_r;
  logic                sat_r;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign acc       = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  assign m_in[0] = in_m00;
  assign m_in[1] = in_m01;
  assign m_in[2] = in_m02;
  assign m_in[3] = in_m10;
  assign m_in[4] = in_m11;
  assign m_in[5] = in_m12;
  assign m_in[6] = in_m20;
  assign m_in[7] = in_m21;
  assign m_in[8] = in_m22;

  mi3_cofactor #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (acc),
    .m_in     (m_in),
    .out_valid(cf_valid),
    .adj      (adj),
    .row0     (row0)
  );

  mi3_det #(.ENTRY_WIDTH(ENTRY_WIDTH), .FRAC_BITS(FRAC_BITS)) u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (cf_valid),
    .adj      (adj),
    .row0     (row0),
    .thr      (thr_r),
    .out_valid(dt_valid),
    .mag      (mag),
    .amag     (amag),
    .tag      (tag)
  );

  for (genvar i = 0; i < N_ENT; i++) begin : g_div
    mi3_divider #(.ENTRY_WIDTH(ENTRY_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dt_valid),
      .num      (amag[i]),
      .den      (mag),
      .tag_in   (tag[i]),
      .out_valid(dv_valid[i]),
      .quo      (quo[i]),
      .ovf      (ovf[i]),
      .tag_out  (dtag[i])
    );
  end

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < N_ENT; i++) begin
      if (dtag[0].sing) begin
        res_nxt[i]  = (i % 4 == 0) ? ONE_VAL : '0;
        lsat_nxt[i] = (i % 4 == 0) ? ONE_SAT : 1'b0;
      end else if (!dtag[i].neg) begin
        lsat_nxt[i] = ovf[i] | quo[i][E] | quo[i][E-1];
        res_nxt[i]  = lsat_nxt[i] ? MAX_VAL : quo[i][E-1:0];
      end else begin
        lsat_nxt[i] = ovf[i] | quo[i][E] | (quo[i][E-1] & (|quo[i][E-2:0]));
        res_nxt[i]  = lsat_nxt[i] ? MIN_VAL : E'(-quo[i][E-1:0]);
      end
      sat_nxt = sat_nxt | lsat_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    sing_r <= dtag[0].sing;
    sat_r  <= sat_nxt;
  end

  assign out_valid     = ov_r;
  assign out_r00       = res_r[0];
  assign out_r01       = res_r[1];
  assign out_r02       = res_r[2];
  assign out_r10       = res_r[3];
  assign out_r11       = res_r[4];
  assign out_r12       = res_r[5];
  assign out_r20       = res_r[6];
  assign out_r21       = res_r[7];
  assign out_r22       = res_r[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;
endmodule

>>> hw/rtl/mi3_cofactor.sv
// Input register, 18 pairwise products and the nine adjugate cofactors.
// Depends on mi3_pkg.
module mi3_cofactor import mi3_pkg::*; #(
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [ENTRY_WIDTH-1:0] m_in [N_ENT],
  output logic                          out_valid,
  output logic signed [2*ENTRY_WIDTH:0] adj [N_ENT],
  output logic signed [ENTRY_WIDTH-1:0] row0 [ROW_N]
);
  localparam int E = ENTRY_WIDTH;
  localparam int P = 2 * E;
  localparam int C = 2 * E + 1;

  logic                v0_r, v1_r, v2_r;
  logic signed [E-1:0] m_r [N_ENT];
  logic signed [E-1:0] r1_r [ROW_N];
  logic signed [E-1:0] r2_r [ROW_N];
  logic signed [P-1:0] prod_r [2*N_ENT];
  logic signed [C-1:0] adj_r [N_ENT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_in;
    for (int k = 0; k < ROW_N; k++) begin
      r1_r[k] <= m_r[k];
      r2_r[k] <= r1_r[k];
    end
  end

  for (genvar i = 0; i < N_ENT; i++) begin : g_cof
    always_ff @(posedge clk) begin
      prod_r[2*i]   <= m_r[COF_IDX[i][0]] * m_r[COF_IDX[i][1]];
      prod_r[2*i+1] <= m_r[COF_IDX[i][2]] * m_r[COF_IDX[i][3]];
      adj_r[i]      <= C'(prod_r[2*i]) - C'(prod_r[2*i+1]);
    end
  end

  assign out_valid = v2_r;
  assign adj       = adj_r;
  assign row0      = r2_r;
endmodule

>>> hw/rtl/mi3_det.sv
// Determinant along the first row, its magnitude, the singular test and
// the adjugate magnitudes and quotient signs. Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [2*ENTRY_WIDTH:0]   adj [N_ENT],
  input  logic signed [ENTRY_WIDTH-1:0]   row0 [ROW_N],
  input  thr_t                            thr,
  output logic                            out_valid,
  output logic [3*ENTRY_WIDTH+2:0]        mag,
  output logic [2*ENTRY_WIDTH:0]          amag [N_ENT],
  output tag_t                            tag [N_ENT]
);
  localparam int E  = ENTRY_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int C  = 2 * E + 1;
  localparam int PW = 2 * E + 1;
  localparam int D  = 3 * E + 3;
  localparam int SW = (D > THR_W + 2 * F) ? D : THR_W + 2 * F;
  localparam int NS = 5;

  logic [NS-1:0]        v_r;
  logic signed [PW-1:0] pl_r [ROW_N];
  logic signed [PW-1:0] ph_r [ROW_N];
  logic signed [D-1:0]  term_r [ROW_N];
  logic signed [D-1:0]  term_nxt [ROW_N];
  logic signed [D-1:0]  det_r;
  logic [D-1:0]         mag_r;
  logic                 dneg_r;
  logic                 sing_r;
  logic [C-1:0]         am_r [NS][N_ENT];
  logic                 an_r [NS][N_ENT];
  logic                 qn_r [N_ENT];
  logic [SW-1:0]        lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < ROW_N; k++) begin
      term_nxt[k] = (D'(ph_r[k]) <<< E) + D'(pl_r[k]);
    end
  end

  assign lim = SW'(thr) << (2 * F);

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROW_N; k++) begin
      pl_r[k]   <= row0[k] * $signed({1'b0, adj[DET_ADJ[k]][E-1:0]});
      ph_r[k]   <= row0[k] * $signed(adj[DET_ADJ[k]][C-1:E]);
      term_r[k] <= term_nxt[k];
    end
    det_r  <= term_r[0] + term_r[1] + term_r[2];
    mag_r  <= det_r[D-1] ? D'(-det_r) : D'(det_r);
    dneg_r <= det_r[D-1];
    sing_r <= SW'(mag_r) <= lim;
    for (int i = 0; i < N_ENT; i++) begin
      am_r[0][i] <= adj[i][C-1] ? C'(-adj[i]) : C'(adj[i]);
      an_r[0][i] <= adj[i][C-1];
      for (int s = 1; s < NS; s++) begin
        am_r[s][i] <= am_r[s-1][i];
        an_r[s][i] <= an_r[s-1][i];
      end
      qn_r[i] <= an_r[NS-2][i] ^ dneg_r;
    end
  end

  logic [D-1:0] mag_d_r;
  always_ff @(posedge clk) begin
    mag_d_r <= mag_r;
  end

  assign out_valid = v_r[NS-1];
  assign mag       = mag_d_r;

  for (genvar i = 0; i < N_ENT; i++) begin : g_out
    assign amag[i]     = am_r[NS-1][i];
    assign tag[i].sing = sing_r;
    assign tag[i].neg  = qn_r[i];
  end
endmodule

>>> hw/rtl/mi3_div_stage.sv
// One quotient bit of the restoring divider: compare, subtract, set bit.
// Depends on mi3_pkg.
module mi3_div_stage import mi3_pkg::*; #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int BIT         = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [((2*ENTRY_WIDTH+1+2*FRAC_BITS) > (4*ENTRY_WIDTH+4) ?
                 (2*ENTRY_WIDTH+1+2*FRAC_BITS) : (4*ENTRY_WIDTH+4))-1:0] rem_in,
  input  logic [3*ENTRY_WIDTH+2:0]            mag_in,
  input  logic [ENTRY_WIDTH:0]                q_in,
  input  logic                                ovf_in,
  input  tag_t                                tag_in,
  output logic                                out_valid,
  output logic [((2*ENTRY_WIDTH+1+2*FRAC_BITS) > (4*ENTRY_WIDTH+4) ?
                 (2*ENTRY_WIDTH+1+2*FRAC_BITS) : (4*ENTRY_WIDTH+4))-1:0] rem_out,
  output logic [3*ENTRY_WIDTH+2:0]            mag_out,
  output logic [ENTRY_WIDTH:0]                q_out,
  output logic                                ovf_out,
  output tag_t                                tag_out
);
  localparam int E = ENTRY_WIDTH;
  localparam int N = 2 * E + 1 + 2 * FRAC_BITS;
  localparam int W = (N > 4 * E + 4) ? N : 4 * E + 4;

  logic         v_r;
  logic [W-1:0] dsh;
  logic         ge;
  logic [W-1:0] rem_r;
  logic [3*E+2:0] mag_r;
  logic [E:0]   q_r;
  logic         ovf_r;
  tag_t         tag_r;

  assign dsh = W'(mag_in) << BIT;
  assign ge  = rem_in >= dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= ge ? rem_in - dsh : rem_in;
    q_r   <= q_in | ((E+1)'(ge) << BIT);
    mag_r <= mag_in;
    ovf_r <= ovf_in;
    tag_r <= tag_in;
  end

  assign out_valid = v_r;
  assign rem_out   = rem_r;
  assign mag_out   = mag_r;
  assign q_out     = q_r;
  assign ovf_out   = ovf_r;
  assign tag_out   = tag_r;
endmodule

>>> hw/rtl/mi3_divider.sv
// Pipelined divider lane: scales the numerator, flags quotient overflow,
// then resolves one quotient bit per stage. Depends on mi3_pkg, mi3_div_stage.
module mi3_divider import mi3_pkg::*; #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [2*ENTRY_WIDTH:0]     num,
  input  logic [3*ENTRY_WIDTH+2:0]   den,
  input  tag_t                       tag_in,
  output logic                       out_valid,
  output logic [ENTRY_WIDTH:0]       quo,
  output logic                       ovf,
  output tag_t                       tag_out
);
  localparam int E = ENTRY_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int N = 2 * E + 1 + 2 * F;
  localparam int W = (N > 4 * E + 4) ? N : 4 * E + 4;
  localparam int D = 3 * E + 3;
  localparam int NB = E + 1;

  logic         v_c [NB+1];
  logic [W-1:0] rem_c [NB+1];
  logic [D-1:0] mag_c [NB+1];
  logic [E:0]   q_c [NB+1];
  logic         ovf_c [NB+1];
  tag_t         tag_c [NB+1];

  logic         v0_r;
  logic [W-1:0] rem0_r;
  logic [D-1:0] mag0_r;
  logic         ovf0_r;
  tag_t         tag0_r;
  logic [W-1:0] num_w;

  assign num_w = W'(num) << (2 * F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem0_r <= num_w;
    mag0_r <= den;
    ovf0_r <= num_w >= (W'(den) << NB);
    tag0_r <= tag_in;
  end

  assign v_c[0]   = v0_r;
  assign rem_c[0] = rem0_r;
  assign mag_c[0] = mag0_r;
  assign q_c[0]   = '0;
  assign ovf_c[0] = ovf0_r;
  assign tag_c[0] = tag0_r;

  for (genvar s = 0; s < NB; s++) begin : g_bit
    mi3_div_stage #(
      .ENTRY_WIDTH(ENTRY_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .BIT        (E - s)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v_c[s]),
      .rem_in   (rem_c[s]),
      .mag_in   (mag_c[s]),
      .q_in     (q_c[s]),
      .ovf_in   (ovf_c[s]),
      .tag_in   (tag_c[s]),
      .out_valid(v_c[s+1]),
      .rem_out  (rem_c[s+1]),
      .mag_out  (mag_c[s+1]),
      .q_out    (q_c[s+1]),
      .ovf_out  (ovf_c[s+1]),
      .tag_out  (tag_c[s+1])
    );
  end

  assign out_valid = v_c[NB];
  assign quo       = q_c[NB];
  assign ovf       = ovf_c[NB];
  assign tag_out   = tag_c[NB];
endmodule

>>> hw/rtl/mi3_checker.sv
// Port-level checks for the matrix inverse and the bind that attaches them.
// Depends on matrix_inverse_3x3.
module mi3_checker #(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic signed [ENTRY_WIDTH-1:0] out_r00,
  input logic signed [ENTRY_WIDTH-1:0] out_r01,
  input logic signed [ENTRY_WIDTH-1:0] out_r02,
  input logic signed [ENTRY_WIDTH-1:0] out_r10,
  input logic signed [ENTRY_WIDTH-1:0] out_r11,
  input logic signed [ENTRY_WIDTH-1:0] out_r12,
  input logic signed [ENTRY_WIDTH-1:0] out_r20,
  input logic signed [ENTRY_WIDTH-1:0] out_r21,
  input logic signed [ENTRY_WIDTH-1:0] out_r22,
  input logic                          out_singular
);
  localparam int E   = ENTRY_WIDTH;
  localparam int LAT = ENTRY_WIDTH + 11;
  localparam logic [E-1:0] ONE_VAL =
    (FRAC_BITS >= E - 1) ? {1'b0, {(E-1){1'b1}}} : (E'(1) << FRAC_BITS);

  a_word_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without a matching start");

  a_sing_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_r01 == '0 && out_r02 == '0 &&
      out_r10 == '0 && out_r12 == '0 && out_r20 == '0 && out_r21 == '0)
    else $error("singular result has nonzero off-diagonal");

  a_sing_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_r00 == ONE_VAL && out_r11 == ONE_VAL &&
      out_r22 == ONE_VAL)
    else $error("singular result diagonal is not one");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");
endmodule

bind matrix_inverse_3x3 mi3_checker #(
  .ENTRY_WIDTH(ENTRY_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_mi3_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for matrix_inverse_3x3: streams 3x3 Q16.16 matrices,
// predicts each exact adjugate/determinant inverse, and compares every result.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
module tb_top;
  import mi3_pkg::*;

  typedef logic [8:0][31:0] mat_t;
  typedef struct packed {
    logic [8:0][31:0] r;
    logic             sing;
    logic             sat;
  } inv_t;
  typedef enum logic [1:0] {CMD_MATRIX, CMD_THRESH, CMD_DRAIN} cmd_kind_e;
  typedef struct packed {
    cmd_kind_e kind;
    thr_t      thr;
    mat_t      m;
  } cmd_t;

  localparam int LIMIT = 200000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [8:0][31:0] drv_m = '0;
  logic out_valid, out_singular, out_saturated;
  logic signed [31:0] out_r [9];
  logic cfg_valid = 0;
  logic cfg_ready;
  thr_t cfg_data = '0;

  cmd_t cmd_q[$];
  inv_t inverse_q[$];
  thr_t thr_model = '0;
  int cycles = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sing = 0;
  int n_sat = 0;
  int n_thr = 0;

  always #5 clk = ~clk;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m00(drv_m[0]), .in_m01(drv_m[1]), .in_m02(drv_m[2]),
    .in_m10(drv_m[3]), .in_m11(drv_m[4]), .in_m12(drv_m[5]),
    .in_m20(drv_m[6]), .in_m21(drv_m[7]), .in_m22(drv_m[8]),
    .out_valid(out_valid),
    .out_r00(out_r[0]), .out_r01(out_r[1]), .out_r02(out_r[2]),
    .out_r10(out_r[3]), .out_r11(out_r[4]), .out_r12(out_r[5]),
    .out_r20(out_r[6]), .out_r21(out_r[7]), .out_r22(out_r[8]),
    .out_singular(out_singular), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic inv_t invert_matrix(mat_t m, thr_t thr);
    logic signed [127:0] e [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det, mag, lim, q;
    logic neg;
    inv_t res;
    for (int i = 0; i < 9; i++) e[i] = $signed(m[i]);
    for (int k = 0; k < 9; k++)
      adj[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]] - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    mag = det < 0 ? -det : det;
    lim = {97'b0, thr} << 32;
    res.sing = (mag <= lim);
    res.sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (res.sing) begin
        res.r[i] = (i % 4 == 0) ? ONE : 32'h0;
      end else begin
        q = ((adj[i] < 0 ? -adj[i] : adj[i]) << 32) / mag;
        neg = (adj[i] < 0) != (det < 0);
        if (!neg && q >= 128'sh8000_0000) begin
          res.r[i] = 32'h7FFF_FFFF;
          res.sat = 1'b1;
        end else if (neg && q > 128'sh8000_0000) begin
          res.r[i] = 32'h8000_0000;
          res.sat = 1'b1;
        end else begin
          res.r[i] = neg ? -q[31:0] : q[31:0];
        end
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] near_unit();
    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
  endfunction

  function automatic mat_t rand_matrix(int mode);
    mat_t m;
    int src;
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: m[i] = near_unit();
        1: m[i] = $urandom;
        2: m[i] = 32'($urandom_range(0, 64)) - 32'd32;
        default: m[i] = near_unit();
      endcase
    end
    if (mode == 3) begin
      src = $urandom_range(0, 2);
      for (int c = 0; c < 3; c++) m[((src + 1) % 3) * 3 + c] = m[src * 3 + c];
    end
    if (mode == 4) for (int i = 0; i < 9; i += 4) m[i] = m[i] + 32'h0004_0000;
    return m;
  endfunction

  task automatic add_matrix(mat_t m);
    cmd_q.push_back('{kind: CMD_MATRIX, thr: '0, m: m});
  endtask

  task automatic add_thresh(thr_t t);
    cmd_q.push_back('{kind: CMD_DRAIN, thr: '0, m: '0});
    cmd_q.push_back('{kind: CMD_THRESH, thr: t, m: '0});
  endtask

  task automatic add_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      add_matrix(rand_matrix(r < 35 ? 0 : r < 60 ? 4 : r < 80 ? 1 : r < 90 ? 2 : 3));
      if ($urandom_range(0, 149) == 0)
        cmd_q.push_back('{kind: CMD_DRAIN, thr: '0, m: '0});
    end
  endtask

  function automatic mat_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    mat_t m;
    m = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        inverse_q.push_back(invert_matrix(drv_m, thr_model));
        void'(cmd_q.pop_front());
        n_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        thr_model = cfg_data;
        void'(cmd_q.pop_front());
        n_thr++;
      end
      if (cmd_q.size() != 0 && !(cfg_valid && !cfg_ready)) begin
        case (cmd_q[0].kind)
          CMD_MATRIX: begin
            cfg_valid <= 1'b0;
            if ((n_sent >= 150 && n_sent < 260) || $urandom_range(0, 99) >= 20) begin
              drv_m <= cmd_q[0].m;
              start <= 1'b1;
            end else begin
              drv_m <= rand_matrix(1);
              start <= 1'b0;
            end
          end
          CMD_THRESH: begin
            start <= 1'b0;
            if (inverse_q.size() == 0) begin
              cfg_data <= cmd_q[0].thr;
              cfg_valid <= 1'b1;
            end
          end
          default: begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            if (inverse_q.size() == 0) void'(cmd_q.pop_front());
          end
        endcase
      end else if (cmd_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    inv_t want;
    if (rst_n && out_valid) begin
      if (inverse_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = inverse_q.pop_front();
        n_checked++;
        if (want.sing) n_sing++;
        if (want.sat) n_sat++;
        for (int i = 0; i < 9; i++)
          if (out_r[i] !== want.r[i]) begin
            $error("r%0d%0d expected %h got %h", i / 3, i % 3, want.r[i], out_r[i]);
            errors++;
          end
        if (out_singular !== want.sing) begin
          $error("singular expected %b got %b", want.sing, out_singular);
          errors++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated expected %b got %b", want.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mat_t m;
    add_thresh('0);
    add_matrix(diag(ONE, ONE, ONE));
    add_matrix('0);
    add_matrix(diag(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000));
    add_matrix(diag(32'd1, 32'd1, 32'd1));
    add_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    add_matrix({9{32'h7FFF_FFFF}});
    add_matrix({9{32'h8000_0000}});
    m = '0;
    m[1] = ONE; m[3] = ONE; m[8] = ONE;
    add_matrix(m);
    m = '0;
    m[2] = 32'h8000_0000; m[4] = 32'h7FFF_FFFF; m[6] = 32'd3;
    add_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = ONE * (i + 1);
    add_matrix(m);
    m[8] = ONE * 10;
    add_matrix(m);
    add_matrix(rand_matrix(3));
    add_matrix(diag(32'h0000_0100, ONE, ONE));
    add_random(150);
    add_thresh(31'd1);
    add_matrix(diag(ONE, ONE, ONE));
    add_matrix(diag(ONE, ONE, 32'h0000_FFFF));
    add_random(100);
    add_thresh(31'h7FFF_FFFF);
    add_random(50);
    add_thresh(31'($urandom_range(0, 2000)));
    add_random(100);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (cmd_q.size() == 0 && inverse_q.size() == 0);
    repeat (60) @(posedge clk);
    if (inverse_q.size() != 0) begin
      $error("%0d result words never arrived", inverse_q.size());
      errors++;
    end
    $display("Inverted %0d matrices over %0d threshold settings;", n_checked, n_thr);
    $display("%0d were singular and %0d saturated, with %0d mismatches.", n_sing, n_sat,
             errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_cofactor.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div_stage.sv
hw/rtl/mi3_divider.sv
hw/rtl/matrix_inverse_3x3.sv
hw/rtl/mi3_checker.sv
test/tb_top.sv
